// File: rtl/core/itoa_pkg.sv
// itoa_pkg: shared types, radix codes and the digit-to-ascii function
// for the integer to ascii radix unit; no dependencies
package itoa_pkg;

  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A_LOWER = 8'h61;
  localparam logic [3:0] DEC_BASE   = 4'd10;

  typedef struct packed {
    logic       load;
    logic       dabble;
    logic       shift;
    logic [2:0] amount;
  } itoa_ctl_t;

  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
    logic [7:0] code;
    if (d < DEC_BASE) begin
      code = CH_ZERO + {4'b0000, d};
    end else begin
      code = CH_A_LOWER + {4'b0000, d - DEC_BASE};
    end
    return code;
  endfunction

endpackage

// File: rtl/core/itoa_cell.sv
// itoa_cell: one 4-bit digit cell of the conversion chain
// does add-3 correction and shifts in bits from its lower neighbor; uses itoa_pkg
module itoa_cell (
  input  logic               clk,
  input  itoa_pkg::itoa_ctl_t ctl,
  input  logic [3:0]         load_digit,
  input  logic [3:0]         lower_pass,
  output logic [3:0]         pass
);
  import itoa_pkg::*;

  logic [3:0] digit;
  logic [7:0] pair;

  assign pass = (ctl.dabble && (digit >= 4'd5)) ? digit + 4'd3 : digit;

  always_comb begin
    pair = {pass, lower_pass} << ctl.amount;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      digit <= load_digit;
    end else if (ctl.shift) begin
      digit <= pair[7:4];
    end
  end

endmodule

// File: rtl/core/integer_to_ascii_radix_unit.sv
// integer_to_ascii_radix_unit: one number in, its ascii digits out msb first
// sequence: a load step, then VALUE_WIDTH shift-and-correct steps for decimal only,
// then each digit slot of the cell chain in turn (leading zero slots dropped one a cycle)
// at VALUE_WIDTH 64 the chain has 21 cells: up to 84 slots binary, 28 octal, 21 hex/decimal
// one number at a time: the next is accepted only after the last digit of the one before
// rst (synchronous, active high) returns the sequencer to idle and empties the output register
module integer_to_ascii_radix_unit #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // value
  input  logic [1:0]  s_tuser,   // base_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // digit_char
  output logic        m_tlast
);
  import itoa_pkg::*;

  localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NC   = ((NDIG + 2) / 3) * 3;
  localparam int CB   = 4 * NC;
  localparam int RW   = $clog2(CB + 1);
  localparam int CW   = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {ST_IDLE, ST_CONVERT, ST_SKIP, ST_EMIT} state_t;

  state_t                 state;
  logic [1:0]             base;
  logic [VALUE_WIDTH-1:0] bin_reg;
  logic [CW-1:0]          bit_cnt;
  logic [RW-1:0]          remaining;

  logic          accept;
  logic          out_free;
  logic          skip_zero;
  logic          emit_now;
  itoa_ctl_t     ctl;
  logic [3:0]    low_in;
  logic [3:0]    top_pass;
  logic [3:0]    digit_val;
  logic [2:0]    step_bits;
  logic [RW-1:0] slot_count;
  logic [CB-1:0] load_bits;
  logic [3:0]    pass [NC];
  logic [3:0]    load_digit [NC];

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign load_bits = CB'(s_tdata[VALUE_WIDTH-1:0]);
  assign top_pass  = pass[NC-1];

  always_comb begin
    case (base)
      BASE_BIN: step_bits = 3'd1;
      BASE_OCT: step_bits = 3'd3;
      default:  step_bits = 3'd4;
    endcase
  end

  always_comb begin
    case (s_tuser)
      BASE_BIN: slot_count = RW'(CB);
      BASE_OCT: slot_count = RW'(CB / 3);
      default:  slot_count = RW'(NC);
    endcase
  end

  always_comb begin
    case (base)
      BASE_BIN: digit_val = {3'b000, top_pass[3]};
      BASE_OCT: digit_val = {1'b0, top_pass[3:1]};
      default:  digit_val = top_pass;
    endcase
  end

  assign skip_zero = (state == ST_SKIP) && (digit_val == 4'd0) && (remaining != RW'(1));
  assign emit_now  = (((state == ST_SKIP) && !skip_zero) || (state == ST_EMIT)) && out_free;

  always_comb begin
    ctl.load   = accept;
    ctl.dabble = (state == ST_CONVERT);
    ctl.shift  = (state == ST_CONVERT) || skip_zero || emit_now;
    ctl.amount = (state == ST_CONVERT) ? 3'd1 : step_bits;
    low_in     = (state == ST_CONVERT) ? {bin_reg[VALUE_WIDTH-1], 3'b000} : 4'd0;
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    assign load_digit[i] = (s_tuser == BASE_DEC) ? 4'd0 : load_bits[4*i +: 4];

    if (i == 0) begin : g_first
      itoa_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .load_digit (load_digit[i]),
        .lower_pass (low_in),
        .pass       (pass[i])
      );
    end else begin : g_next
      itoa_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .load_digit (load_digit[i]),
        .lower_pass (pass[i-1]),
        .pass       (pass[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (emit_now) begin
        m_tvalid  <= 1'b1;
        m_tdata   <= digit_to_ascii(digit_val);
        m_tlast   <= (remaining == RW'(1));
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            base      <= s_tuser;
            bin_reg   <= s_tdata[VALUE_WIDTH-1:0];
            bit_cnt   <= CW'(VALUE_WIDTH - 1);
            remaining <= slot_count;
            state     <= (s_tuser == BASE_DEC) ? ST_CONVERT : ST_SKIP;
          end
        end
        ST_CONVERT: begin
          bin_reg <= bin_reg << 1;
          bit_cnt <= bit_cnt - CW'(1);
          if (bit_cnt == CW'(0)) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip_zero) begin
            remaining <= remaining - RW'(1);
          end else if (emit_now) begin
            remaining <= remaining - RW'(1);
            state     <= (remaining == RW'(1)) ? ST_IDLE : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_now) begin
            remaining <= remaining - RW'(1);
            if (remaining == RW'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_remaining_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_EMIT) |-> (remaining != RW'(0)))
    else $error("digit slot count ran out before the last digit");

  a_bcd_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SKIP || state == ST_EMIT) && base == BASE_DEC) |-> (top_pass <= 4'd9))
    else $error("decimal cell holds a non-bcd digit");

  a_first_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP && emit_now && remaining != RW'(1)) |-> (digit_val != 4'd0))
    else $error("leading zero digit emitted");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_now && remaining == RW'(1)) |=> (state == ST_IDLE && m_tvalid && m_tlast))
    else $error("last digit did not close the number");

endmodule

// File: sim/integer_to_ascii_radix_checker.sv
// integer_to_ascii_radix_checker: watches both stream channels of the radix unit,
// predicts the ascii digits of every accepted number and compares them in order
// depends on itoa_pkg for the radix codes and character constants
`timescale 1ns / 100ps

module integer_to_ascii_radix_checker #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // value
  input  logic [1:0]  s_tuser,   // base_select
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // digit_char
  input  logic        m_tlast,
  output int          fail_count,
  output int          numbers_taken,
  output int          digits_checked,
  output int          digits_pending
);
  import itoa_pkg::*;

  typedef struct packed {
    logic [7:0] digit_char;
    logic       last_digit;
  } digit_word_t;

  digit_word_t digits_due[$];

  initial begin
    fail_count     = 0;
    numbers_taken  = 0;
    digits_checked = 0;
    digits_pending = 0;
  end

  function automatic logic [7:0] ascii_of(input logic [63:0] d);
    logic [7:0] code;
    if (d < 64'd10) begin
      code = CH_ZERO + d[7:0];
    end else begin
      code = CH_A_LOWER + (d[7:0] - 8'd10);
    end
    return code;
  endfunction

  function automatic void predict_digits(input logic [63:0] value, input logic [1:0] base);
    logic [63:0] num;
    logic [63:0] radix;
    logic [7:0]  reversed [64];
    int          count;
    digit_word_t w;
    num = (VALUE_WIDTH >= 64) ? value : (value & ((64'd1 << VALUE_WIDTH) - 64'd1));
    case (base)
      BASE_BIN: radix = 64'd2;
      BASE_OCT: radix = 64'd8;
      BASE_DEC: radix = 64'd10;
      default:  radix = 64'd16;
    endcase
    count = 0;
    do begin
      reversed[count] = ascii_of(num % radix);
      count++;
      num = num / radix;
    end while (num != 64'd0 && count < 64);
    for (int k = count - 1; k >= 0; k--) begin
      w.digit_char = reversed[k];
      w.last_digit = (k == 0);
      digits_due.push_back(w);
    end
  endfunction

  function automatic void note_failure();
    fail_count++;
  endfunction

  always @(posedge clk) begin
    digit_word_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_digits(s_tdata, s_tuser);
        numbers_taken <= numbers_taken + 1;
      end
      if (m_tvalid && m_tready) begin
        digits_checked <= digits_checked + 1;
        if (digits_due.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected digit word %h last %b", $realtime, m_tdata, m_tlast);
          end
          note_failure();
        end else begin
          want = digits_due.pop_front();
          if (want.digit_char !== m_tdata || want.last_digit !== m_tlast) begin
            if (fail_count < 10) begin
              $display("%0t: digit mismatch, expected %h last %b, got %h last %b",
                       $realtime, want.digit_char, want.last_digit, m_tdata, m_tlast);
            end
            note_failure();
          end
        end
      end
      digits_pending <= digits_due.size();
    end
  end

endmodule

// File: sim/integer_to_ascii_radix_unit_tb.sv
// integer_to_ascii_radix_unit_tb: drives numbers in all four radixes into the unit,
// stalls both sides at random and reports the verdict of the checker
// depends on itoa_pkg, integer_to_ascii_radix_unit and integer_to_ascii_radix_checker
`timescale 1ns / 100ps

module integer_to_ascii_radix_unit_tb;
  import itoa_pkg::*;

  localparam int RANDOM_NUMBERS = 300;
  localparam int QUIET_TAIL     = 40;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES   = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // value
  logic [1:0]  s_tuser = '0;   // base_select
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // digit_char
  logic        m_tlast;

  int  fail_count;
  int  numbers_taken;
  int  digits_checked;
  int  digits_pending;
  int  cycles = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;
  int  base_hits [4];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  integer_to_ascii_radix_unit #(.VALUE_WIDTH(64)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  integer_to_ascii_radix_checker #(.VALUE_WIDTH(64)) checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .numbers_taken(numbers_taken),
    .digits_checked(digits_checked), .digits_pending(digits_pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits outstanding", cycles, digits_pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver drops m_tready at random, in bursts; it is held ready during reset and the quiet tail
  always @(negedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_number(input logic [63:0] value, input logic [1:0] base);
    int gap;
    int taken_before;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= value;
    s_tuser  <= base;
    s_tvalid <= 1'b1;
    taken_before = numbers_taken;
    do @(negedge clk); while (numbers_taken == taken_before);
    base_hits[base]++;
  endtask

  task automatic wait_all_digits();
    s_tvalid <= 1'b0;
    while (digits_pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [63:0] value;
    logic [1:0]  base;
    foreach (base_hits[b]) base_hits[b] = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero and all ones in every radix
    send_number(64'd0, BASE_BIN);
    send_number(64'd0, BASE_OCT);
    send_number(64'd0, BASE_DEC);
    send_number(64'd0, BASE_HEX);
    send_number('1, BASE_BIN);
    send_number('1, BASE_OCT);
    send_number('1, BASE_DEC);
    send_number('1, BASE_HEX);
    // digit boundaries and the letter range
    send_number(64'd1, BASE_BIN);
    send_number(64'h8000_0000_0000_0000, BASE_BIN);
    send_number(64'd7, BASE_OCT);
    send_number(64'd8, BASE_OCT);
    send_number(64'd9, BASE_DEC);
    send_number(64'd10, BASE_DEC);
    send_number(64'd10, BASE_HEX);
    send_number(64'd15, BASE_HEX);
    send_number(64'd16, BASE_HEX);
    send_number(64'h0123_4567_89ab_cdef, BASE_HEX);
    send_number(64'hfedc_ba98_7654_3210, BASE_HEX);
    send_number(64'd10000000000000000000, BASE_DEC);
    send_number(64'd9999999999999999999, BASE_DEC);
    send_number(64'h5555_5555_5555_5555, BASE_OCT);
    wait_all_digits();

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i == RANDOM_NUMBERS / 2) wait_all_digits();
      if (i == RANDOM_NUMBERS - QUIET_TAIL) quiet = 1'b1;
      value = {$urandom(), $urandom()};
      case ($urandom_range(0, 3))
        0: ;
        1: value = value >> $urandom_range(1, 63);
        2: value = 64'($urandom_range(0, 1000));
        default: value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      endcase
      base = 2'($urandom_range(0, 3));
      send_number(value, base);
    end
    s_tvalid <= 1'b0;

    while (digits_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("converted %0d numbers into %0d digits in %0d cycles", numbers_taken,
             digits_checked, cycles);
    $display("radix mix: binary %0d, octal %0d, decimal %0d, hex %0d", base_hits[BASE_BIN],
             base_hits[BASE_OCT], base_hits[BASE_DEC], base_hits[BASE_HEX]);
    if (fail_count == 0 && digits_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d digits never arrived", fail_count, digits_pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
